// File: rtl/cdad_pkg.sv
`timescale 1ns / 1ps

package cdad_pkg;

	// Field widths
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 16;

	// Calendar constants
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] LEN_NONE  = 5'd0;
	localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
	localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
	localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
	localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;

	localparam logic [YEAR_W-1:0] YEAR_CYCLE   = 14'd400;
	localparam logic [YEAR_W-1:0] YEAR_CENTURY = 14'd100;

	// Request and response payloads
	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [COUNT_W-1:0] day_count;
	} cdad_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]   result_day;
		logic [MONTH_W-1:0] result_month;
		logic [YEAR_W-1:0]  result_year;
	} cdad_rsp_t;

	// Days in a month; invalid months and year zero have no days
	function automatic logic [DAY_W-1:0] month_length(
		input logic [MONTH_W-1:0] m,
		input logic               leap,
		input logic               year_zero
	);
		logic [DAY_W-1:0] len;
		len = LEN_LONG;
		if (year_zero) begin
			len = LEN_NONE;
		end else begin
			case (m) inside
				4'd0, [4'd13:4'd15]:                      len = LEN_NONE;
				MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
				MONTH_FEB:                                len = leap ? LEN_LEAP : LEN_FEB;
				default:                                  len = LEN_LONG;
			endcase
		end
		return len;
	endfunction

endpackage

// File: rtl/calendar_date_add_days.sv
`timescale 1ns / 1ps

// Gregorian date advance: adds day_count days to the start date. A transaction is
// taken when start is high and busy is low; busy then stays high until the result
// is shown on result for the single cycle in which done is high. Results cannot be
// held off, so capture them on done. After the accepting edge the block first
// reduces the year modulo 400 by repeated compare-subtract of 400, then steps: each
// step crosses one month boundary or, when the count runs out inside a month, adds
// the rest of the count, and a final step with a zero count registers the result
// and raises done. The shared add/compare unit moves the date either to the first
// of the next month or by the rest of the count in each step. A zero count returns
// the start date as given.
module calendar_date_add_days
	import cdad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cdad_req_t item,
	output logic      done,
	output cdad_rsp_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_STEP
	} state_t;

	state_t             state_q;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [COUNT_W-1:0] count_q;
	logic [YEAR_W-1:0]  r400_q;   // year first, then year mod 400
	logic               done_q;
	cdad_rsp_t          result_q;

	// Leap test from year mod 400
	logic             century;
	logic             leap;
	logic [DAY_W-1:0] len;
	logic [DAY_W:0]   room;
	logic             in_month;
	logic             take_rest;

	always_comb begin
		century = (r400_q == '0) || (r400_q == YEAR_CENTURY)
			|| (r400_q == YEAR_CENTURY + YEAR_CENTURY)
			|| (r400_q == YEAR_CYCLE - YEAR_CENTURY);
		leap      = ((year_q[1:0] == 2'b00) && !century) || (r400_q == '0);
		len       = month_length(month_q, leap, year_q == '0);
		in_month  = day_q < len;
		room      = {1'b0, len} - {1'b0, day_q};
		// the remaining count ends inside this month
		take_rest = count_q <= COUNT_W'(room);
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						day_q   <= item.start_day;
						month_q <= item.start_month;
						year_q  <= item.start_year;
						count_q <= item.day_count;
						r400_q  <= item.start_year;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (r400_q >= YEAR_CYCLE) begin
						r400_q <= r400_q - YEAR_CYCLE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (count_q == '0) begin
						result_q.result_day   <= day_q;
						result_q.result_month <= month_q;
						result_q.result_year  <= year_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (in_month && take_rest) begin
						day_q   <= day_q + count_q[DAY_W-1:0];
						count_q <= '0;
					end else begin
						// roll to the first of the next month
						day_q <= DAY_W'(1);
						if (in_month) begin
							count_q <= count_q - COUNT_W'(room) - COUNT_W'(1);
						end else begin
							count_q <= count_q - COUNT_W'(1);
						end
						if (month_q < MONTH_DEC) begin
							month_q <= month_q + MONTH_W'(1);
						end else begin
							month_q <= MONTH_JAN;
							year_q  <= year_q + YEAR_W'(1);
							if ((year_q == '1) || (r400_q == YEAR_CYCLE - YEAR_W'(1))) begin
								r400_q <= '0;
							end else begin
								r400_q <= r400_q + YEAR_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a transaction in progress");

	// the strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted transaction makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// the year residue stays reduced while stepping
	a_r400_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (r400_q < YEAR_CYCLE))
		else $error("year residue out of range");

	// residue and year agree modulo 4
	a_r400_mod4: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (r400_q[1:0] == year_q[1:0]))
		else $error("year residue out of step with year");
`endif

endmodule
